// ===== hw/rtl/arr_pkg.sv =====
// shared types and constants for the aspect ratio reducer
`default_nettype none
package arr_pkg;

    localparam int FIELD_WIDTH = 16;
    localparam int IN_FIELDS   = 4;
    localparam int IN_TDATA_W  = ((IN_FIELDS * FIELD_WIDTH + 7) / 8) * 8;
    localparam int PROD_W      = 32;
    localparam int OUT_TDATA_W = 2 * PROD_W;
    localparam int K_W         = $clog2(PROD_W);
    localparam int DIV_STEPS   = PROD_W;
    localparam int CNT_W       = $clog2(DIV_STEPS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_GCD,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic mul;
        logic gcd_step;
        logic div_init;
        logic div_step;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic gcd_done;
        logic div_done;
    } t_dp_status;

endpackage
`default_nettype wire

// ===== hw/rtl/aspect_ratio_reducer.sv =====
// top level: sample aspect ratio and picture size to reduced display aspect ratio
//
//  channel  direction  tdata (low bit up)                          tuser
//  s_axis   in         sar_x, sar_y, pic_width, pic_height (16 ea) -
//  m_axis   out        dar_x (32), dar_y (32)                      ratio_valid
//
//  one transaction at a time: accept, multiply, up to 63 binary gcd steps,
//  divisor setup, 32 restoring division steps, division end check, output
//  load; only the length of the gcd subtract loop varies with the operands
//  the result sits in an output register, so the next transaction is taken
//  while it waits; a stalled output only holds back the load of the one after
//  synchronous active-low reset clears the controller and the output valid
`default_nettype none
module aspect_ratio_reducer (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_axis_tvalid,
    output      logic                            o_s_axis_tready,
    // sar_x, sar_y, pic_width, pic_height
    input  wire logic [arr_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    output      logic                            o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    // dar_x, dar_y
    output      logic [arr_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    // ratio_valid
    output      logic [0:0]                      o_m_axis_tuser
);

    arr_pkg::t_dp_cmd    w_cmd;
    arr_pkg::t_dp_status w_status;

    arr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_cmd       (w_cmd),
        .i_status    (w_status)
    );

    arr_dp u_dp (
        .i_clk      (i_clk),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .i_in_data  (i_s_axis_tdata),
        .o_out_data (o_m_axis_tdata),
        .o_out_flag (o_m_axis_tuser[0])
    );

endmodule
`default_nettype wire

// ===== hw/rtl/arr_dp.sv =====
// datapath: products, binary gcd, two restoring dividers, output register
`default_nettype none
module arr_dp (
    input  wire logic                            i_clk,
    input  wire arr_pkg::t_dp_cmd                i_cmd,
    output      arr_pkg::t_dp_status             o_status,
    input  wire logic [arr_pkg::IN_TDATA_W-1:0]  i_in_data,
    output      logic [arr_pkg::OUT_TDATA_W-1:0] o_out_data,
    output      logic                            o_out_flag
);

    localparam int FW = arr_pkg::FIELD_WIDTH;
    localparam int PW = arr_pkg::PROD_W;
    localparam int KW = arr_pkg::K_W;
    localparam int CW = arr_pkg::CNT_W;

    logic [FW-1:0] r_sar_x, r_sar_y, r_width, r_height;
    logic [PW-1:0] r_dw, r_dh;
    logic [PW-1:0] r_a, r_b, n_a, n_b;
    logic [KW-1:0] r_k, n_k;
    logic [PW-1:0] r_g;
    logic [PW-1:0] r_qx, r_qy, r_rx, r_ry;
    logic [CW-1:0] r_cnt;
    logic [PW-1:0] r_dar_x, r_dar_y;
    logic          r_flag;

    logic [PW-1:0] w_a_minus_b, w_b_minus_a;
    logic [PW:0]   w_rx_sh, w_ry_sh;
    logic          w_x_ge, w_y_ge;

    assign w_a_minus_b = r_a - r_b;
    assign w_b_minus_a = r_b - r_a;

    // one binary gcd step: strip twos, otherwise subtract the smaller odd value
    always_comb begin
        n_a = r_a;
        n_b = r_b;
        n_k = r_k;
        if (!r_a[0] && !r_b[0]) begin
            n_a = r_a >> 1;
            n_b = r_b >> 1;
            n_k = r_k + KW'(1);
        end else if (!r_a[0]) begin
            n_a = r_a >> 1;
        end else if (!r_b[0]) begin
            n_b = r_b >> 1;
        end else if (r_a >= r_b) begin
            n_a = w_a_minus_b >> 1;
        end else begin
            n_b = w_b_minus_a >> 1;
        end
    end

    assign w_rx_sh = {r_rx, r_qx[PW-1]};
    assign w_ry_sh = {r_ry, r_qy[PW-1]};
    assign w_x_ge  = w_rx_sh >= {1'b0, r_g};
    assign w_y_ge  = w_ry_sh >= {1'b0, r_g};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sar_x  <= i_in_data[0*FW +: FW];
            r_sar_y  <= i_in_data[1*FW +: FW];
            r_width  <= i_in_data[2*FW +: FW];
            r_height <= i_in_data[3*FW +: FW];
        end
        if (i_cmd.mul) begin
            // products wrap modulo 2^32
            r_dw <= PW'(PW'(r_width) * PW'(r_sar_x));
            r_dh <= PW'(PW'(r_height) * PW'(r_sar_y));
            r_a  <= PW'(PW'(r_width) * PW'(r_sar_x));
            r_b  <= PW'(PW'(r_height) * PW'(r_sar_y));
            r_k  <= '0;
        end else if (i_cmd.gcd_step) begin
            r_a <= n_a;
            r_b <= n_b;
            r_k <= n_k;
        end
        if (i_cmd.div_init) begin
            // one of a, b is zero here
            r_g   <= (r_a | r_b) << r_k;
            r_qx  <= r_dw;
            r_qy  <= r_dh;
            r_rx  <= '0;
            r_ry  <= '0;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rx  <= w_x_ge ? PW'(w_rx_sh - {1'b0, r_g}) : PW'(w_rx_sh);
            r_ry  <= w_y_ge ? PW'(w_ry_sh - {1'b0, r_g}) : PW'(w_ry_sh);
            r_qx  <= {r_qx[PW-2:0], w_x_ge};
            r_qy  <= {r_qy[PW-2:0], w_y_ge};
            r_cnt <= r_cnt + CW'(1);
        end
        if (i_cmd.out_load) begin
            if (r_g == '0) begin
                r_dar_x <= '0;
                r_dar_y <= '0;
                r_flag  <= 1'b0;
            end else begin
                r_dar_x <= r_qx;
                r_dar_y <= r_qy;
                r_flag  <= 1'b1;
            end
        end
    end

    assign o_status.gcd_done = (r_a == '0) || (r_b == '0);
    assign o_status.div_done = (r_cnt == CW'(arr_pkg::DIV_STEPS));
    assign o_out_data        = {r_dar_y, r_dar_x};
    assign o_out_flag        = r_flag;

endmodule
`default_nettype wire

// ===== hw/rtl/arr_ctrl.sv =====
// controller state machine and output valid flag
`default_nettype none
module arr_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output      logic                o_in_ready,
    output      logic                o_out_valid,
    input  wire logic                i_out_ready,
    output      arr_pkg::t_dp_cmd    o_cmd,
    input  wire arr_pkg::t_dp_status i_status
);

    arr_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;
    logic            w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            arr_pkg::ST_IDLE: if (i_in_valid) n_state = arr_pkg::ST_MUL;
            arr_pkg::ST_MUL:  n_state = arr_pkg::ST_GCD;
            arr_pkg::ST_GCD:  if (i_status.gcd_done) n_state = arr_pkg::ST_DIV;
            arr_pkg::ST_DIV:  if (i_status.div_done) n_state = arr_pkg::ST_DONE;
            arr_pkg::ST_DONE: if (w_out_free) n_state = arr_pkg::ST_IDLE;
            default:          n_state = arr_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            arr_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            arr_pkg::ST_MUL: o_cmd.mul = 1'b1;
            arr_pkg::ST_GCD: begin
                o_cmd.gcd_step = !i_status.gcd_done;
                o_cmd.div_init = i_status.gcd_done;
            end
            arr_pkg::ST_DIV:  o_cmd.div_step = !i_status.div_done;
            arr_pkg::ST_DONE: o_cmd.out_load = w_out_free;
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= arr_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

// ===== hw/rtl/arr_chk.sv =====
// port-level checks for the aspect ratio reducer, bound to the top level
`default_nettype none
module arr_chk (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_s_axis_tvalid,
    input wire logic                            o_s_axis_tready,
    input wire logic                            o_m_axis_tvalid,
    input wire logic                            i_m_axis_tready,
    input wire logic [arr_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    input wire logic [0:0]                      o_m_axis_tuser
);

    // nothing valid right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled output changed");

    // one transaction in work at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input taken while busy");

    // an invalid ratio carries zeros
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[0] |-> o_m_axis_tdata == '0)
        else $error("invalid ratio with nonzero terms");

    // a valid ratio has a nonzero term
    a_valid_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |-> o_m_axis_tdata != '0)
        else $error("valid ratio with both terms zero");

endmodule

bind aspect_ratio_reducer arr_chk u_arr_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
`default_nettype wire

// ===== tb/sv/dar_monitor.sv =====
`timescale 1ns / 100ps
// channel monitor for the aspect ratio reducer: predicts each reduced ratio and compares
module dar_monitor (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_tvalid,
    input  logic                            i_in_tready,
    // sar_x, sar_y, pic_width, pic_height
    input  logic [arr_pkg::IN_TDATA_W-1:0]  i_in_tdata,
    input  logic                            i_out_tvalid,
    input  logic                            i_out_tready,
    // dar_x, dar_y
    input  logic [arr_pkg::OUT_TDATA_W-1:0] i_out_tdata,
    // ratio_valid
    input  logic [0:0]                      i_out_tuser,
    output int                              o_errors,
    output int                              o_pending,
    output int                              o_results,
    output int                              o_no_divisor
);

    localparam int FW = arr_pkg::FIELD_WIDTH;
    localparam int PW = arr_pkg::PROD_W;

    typedef struct packed {
        logic [PW-1:0] dar_x;
        logic [PW-1:0] dar_y;
        logic          ratio_valid;
    } t_dar;

    t_dar expected_dar[$];
    int   error_count = 0;
    int   result_count = 0;
    int   no_div_count = 0;

    // display products wrap to 32 bits before the euclid loop
    function automatic t_dar reduce_ratio(input logic [FW-1:0] sx, sy, w, h);
        logic [63:0]   full_w;
        logic [63:0]   full_h;
        logic [PW-1:0] a;
        logic [PW-1:0] b;
        logic [PW-1:0] r;
        t_dar          res;
        full_w = 64'(w) * 64'(sx);
        full_h = 64'(h) * 64'(sy);
        a = full_w[PW-1:0];
        b = full_h[PW-1:0];
        while (b != 0) begin
            r = a % b;
            a = b;
            b = r;
        end
        if (a != 0) begin
            res.dar_x = full_w[PW-1:0] / a;
            res.dar_y = full_h[PW-1:0] / a;
            res.ratio_valid = 1'b1;
        end else begin
            res = '0;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_dar got;
        t_dar want;
        if (i_rst_n) begin
            // results first: a transaction taken at this edge cannot come out at it
            if (i_out_tvalid && i_out_tready) begin
                got.dar_x = i_out_tdata[PW-1:0];
                got.dar_y = i_out_tdata[2*PW-1:PW];
                got.ratio_valid = i_out_tuser[0];
                result_count++;
                if (!got.ratio_valid)
                    no_div_count++;
                if (expected_dar.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result dar_x=%0d dar_y=%0d valid=%0b",
                             $time, got.dar_x, got.dar_y, got.ratio_valid);
                end else begin
                    want = expected_dar.pop_front();
                    if (got.dar_x !== want.dar_x) begin
                        error_count++;
                        $display("%0t: dar_x mismatch: expected %0d, actual %0d",
                                 $time, want.dar_x, got.dar_x);
                    end
                    if (got.dar_y !== want.dar_y) begin
                        error_count++;
                        $display("%0t: dar_y mismatch: expected %0d, actual %0d",
                                 $time, want.dar_y, got.dar_y);
                    end
                    if (got.ratio_valid !== want.ratio_valid) begin
                        error_count++;
                        $display("%0t: ratio_valid mismatch: expected %0b, actual %0b",
                                 $time, want.ratio_valid, got.ratio_valid);
                    end
                end
            end
            if (i_in_tvalid && i_in_tready)
                expected_dar.push_back(reduce_ratio(
                    i_in_tdata[FW-1:0],
                    i_in_tdata[2*FW-1:FW],
                    i_in_tdata[3*FW-1:2*FW],
                    i_in_tdata[4*FW-1:3*FW]));
        end
        o_errors <= error_count;
        o_pending <= expected_dar.size();
        o_results <= result_count;
        o_no_divisor <= no_div_count;
    end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// top of the aspect ratio reducer testbench: clock, reset, stimulus and verdict
module testbench;

    localparam int LIMIT_CYCLES = 1_500_000;
    localparam int DRAIN_CYCLES = 200;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_ITEMS = 1600;
    localparam int FW           = arr_pkg::FIELD_WIDTH;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic [arr_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
    logic                            m_tready = 1'b0;
    logic                            s_tready;
    logic                            m_tvalid;
    logic [arr_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic [0:0]                      m_tuser;

    int   mon_errors;
    int   mon_pending;
    int   mon_results;
    int   mon_no_divisor;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   cycle_count = 0;
    int   sent = 0;
    logic hold_req = 1'b0;
    logic hold_rx = 1'b0;

    aspect_ratio_reducer uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    dar_monitor mon (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_tvalid  (s_tvalid),
        .i_in_tready  (s_tready),
        .i_in_tdata   (s_tdata),
        .i_out_tvalid (m_tvalid),
        .i_out_tready (m_tready),
        .i_out_tdata  (m_tdata),
        .i_out_tuser  (m_tuser),
        .o_errors     (mon_errors),
        .o_pending    (mon_pending),
        .o_results    (mon_results),
        .o_no_divisor (mon_no_divisor)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     mon_pending);
            $display("FAIL");
            $finish;
        end
    end

    always @(negedge clk) begin
        if (hold_rx)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // long receiver hold-off, counted on its own
    initial begin
        forever begin
            wait (hold_req);
            @(posedge clk);
            hold_rx = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_rx = 1'b0;
            hold_req = 1'b0;
        end
    end

    task automatic offer_item(input logic [FW-1:0] sx, sy, w, h);
        @(negedge clk);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata <= arr_pkg::IN_TDATA_W'({h, w, sy, sx});
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sent++;
    endtask

    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (mon_pending != 0) @(negedge clk);
    endtask

    function automatic logic [FW-1:0] pick_field();
        logic [FW-1:0] v;
        case ($urandom_range(9))
            0: v = '0;
            1: v = FW'($urandom_range(1, 20));
            2: v = ~FW'($urandom_range(0, 7));
            3: v = FW'(1) << $urandom_range(FW - 1);
            4: v = FW'($urandom_range(1, 256) * 16);   // typical picture sizes
            default: v = FW'($urandom);
        endcase
        return v;
    endfunction

    initial begin
        logic [FW-1:0] sx;
        logic [FW-1:0] sy;
        logic [FW-1:0] w;
        logic [FW-1:0] h;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 10;
        recv_idle_pct = 74;
        // zero products, one-sided zero, common formats, extremes, bit patterns
        offer_item(0, 0, 0, 0);
        offer_item(3, 4, 0, 0);
        offer_item(0, 0, '1, '1);
        offer_item(0, 5, 7, 3);
        offer_item(5, 0, 7, 3);
        offer_item(1, 1, 1, 1);
        offer_item(1, 1, 1920, 1080);
        offer_item(64, 45, 720, 576);
        offer_item(4, 3, 1440, 1080);
        offer_item('1, '1, '1, '1);
        offer_item('1, 1, '1, 1);
        offer_item(1, '1, 1, '1);
        offer_item(65521, 65497, 65519, 65447);
        offer_item(16'h8000, 1, 16'h8000, 2);
        offer_item(16'haaaa, 16'h5555, 16'haaaa, 16'h5555);
        offer_item(16'h5555, 16'haaaa, 16'h5555, 16'haaaa);
        offer_item(12, 18, 30, 20);

        for (int p = 0; p < 3; p++) begin
            drain_results();
            send_idle_pct = (p == 0) ? 10 : (p == 1) ? 74 : 0;
            recv_idle_pct = (p == 0) ? 74 : (p == 1) ? 10 : 0;
            for (int n = 0; n < RANDOM_ITEMS / 3; n++) begin
                if (p == 0 && n == 200)
                    drain_results();
                if (p == 2 && n == 60)
                    hold_req = 1'b1;
                sx = pick_field();
                sy = pick_field();
                w = pick_field();
                h = pick_field();
                // equal nonzero products give 1:1 whatever their size
                if ($urandom_range(7) == 0) begin
                    sy = sx;
                    h = w;
                end
                offer_item(sx, sy, w, h);
            end
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (mon_pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d input transactions and %0d results, %0d with no divisor",
                 sent, mon_results, mon_no_divisor);
        $display("mixed sender and receiver idling, a long receiver hold-off, mid-run drain");
        if (mon_errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
